### rtl/core/pgba_pkg.sv
package pgba_pkg;

  localparam int COORD_W  = 24;
  localparam int SCALE_W  = 32;
  localparam int INTEN_W  = 16;
  localparam int RDIDX_W  = 6;
  localparam int VALUE_W  = 24;
  localparam int CNT_W    = 16;
  localparam int SUM_W    = 40;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W   = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = DIFF_W + SCALE_W + 1;
  localparam int IDX_W    = PROD_W - FRAC_W;
  localparam int STEP_W   = $clog2(SUM_W);

  localparam int DEF_GRID_WIDTH  = 64;
  localparam int DEF_GRID_HEIGHT = 64;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_HEIGHT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTENSITY = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MULX,
    S_MULY,
    S_ADDR,
    S_RADDR,
    S_RD,
    S_RMW,
    S_DIV,
    S_DONE
  } state_t;

endpackage

### rtl/core/point_grid_binning_averager.sv
// Channel  | Direction | Handshake          | Payload
// cfg      | in        | cfg_we             | cfg_idx, cfg_wdata
// in       | in        | in_valid/in_ready  | mode, point x/y/z, intensity, read col/row
// out      | out       | out_valid/out_ready| flags, cell col/row, value, count
//
// Add transfer: two passes of the shared 25x33 multiplier, cell read,
// read-modify-write, result. A read transfer uses the bit-serial
// divider as well when the average kind reads a non-empty cell.
// After reset a clearing pass writes every cell with in_ready low. A stalled
// result holds in the output register; the next input transfer is taken
// meanwhile and waits at its last step.
module point_grid_binning_averager #(
  parameter int GRID_WIDTH  = pgba_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = pgba_pkg::DEF_GRID_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pgba_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [pgba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [pgba_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [pgba_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [pgba_pkg::COORD_W-1:0]  in_point_z,
  input  logic [pgba_pkg::INTEN_W-1:0]         in_intensity,
  input  logic [pgba_pkg::RDIDX_W-1:0]         in_read_col,
  input  logic [pgba_pkg::RDIDX_W-1:0]         in_read_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_accepted,
  output logic                                 out_outside_grid,
  output logic                                 out_saturated,
  output logic [pgba_pkg::RDIDX_W-1:0]         out_cell_col,
  output logic [pgba_pkg::RDIDX_W-1:0]         out_cell_row,
  output logic signed [pgba_pkg::VALUE_W-1:0]  out_cell_value,
  output logic [pgba_pkg::CNT_W-1:0]           out_cell_count
);
  import pgba_pkg::*;

  localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int COL_W  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int ROW_W  = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int MEM_W  = SUM_W + CNT_W;
  localparam int RCMP_W = 11;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NCELLS - 1);
  localparam logic [ADDR_W-1:0] GW_A      = ADDR_W'(GRID_WIDTH);
  localparam logic [IDX_W-1:0]  LIM_X     = IDX_W'(GRID_WIDTH);
  localparam logic [IDX_W-1:0]  LIM_Y     = IDX_W'(GRID_HEIGHT);
  localparam logic [RCMP_W-1:0] RLIM_X    = RCMP_W'(GRID_WIDTH);
  localparam logic [RCMP_W-1:0] RLIM_Y    = RCMP_W'(GRID_HEIGHT);

  state_t state_r, state_nxt;

  logic [KIND_W-1:0]         kind_r;
  logic [COORD_W-1:0]        org_x_r, org_y_r;
  logic [SCALE_W-1:0]        scl_x_r, scl_y_r;

  logic                      mode_r;
  logic [COORD_W-1:0]        x_r, y_r, z_r;
  logic [INTEN_W-1:0]        inten_r;
  logic [RDIDX_W-1:0]        rcol_r, rrow_r;

  logic [ADDR_W-1:0]         clr_cnt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [COL_W-1:0]          col_r;
  logic [ROW_W-1:0]          row_r;
  logic [ADDR_W-1:0]         addr_r;
  logic                      outside_r, acc_r, sat_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [VALUE_W-1:0]        value_r;
  logic                      neg_r;
  logic [SUM_W-1:0]          quo_r;
  logic [CNT_W-1:0]          rem_r;
  logic [STEP_W-1:0]         step_r;

  logic [MEM_W-1:0]          mem [NCELLS];
  logic [MEM_W-1:0]          rdata_r;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [MEM_W-1:0]          mem_wdata;

  logic                      out_valid_r, out_load;
  logic                      out_acc_r, out_out_r, out_sat_r;
  logic [RDIDX_W-1:0]        out_col_r, out_row_r;
  logic [VALUE_W-1:0]        out_val_r;
  logic [CNT_W-1:0]          out_cnt_r;

  // shared multiplier
  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [SCALE_W:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [COORD_W-1:0]        mul_coord, mul_org;
  logic [SCALE_W-1:0]        mul_scl;

  always_comb begin
    if (state_r == S_MULX) begin
      mul_coord = x_r;
      mul_org   = org_x_r;
      mul_scl   = scl_x_r;
    end else begin
      mul_coord = y_r;
      mul_org   = org_y_r;
      mul_scl   = scl_y_r;
    end
  end

  assign mul_a = $signed({mul_coord[COORD_W-1], mul_coord}) -
                 $signed({mul_org[COORD_W-1], mul_org});
  assign mul_b = $signed({1'b0, mul_scl});
  assign mul_p = mul_a * mul_b;

  logic [IDX_W-1:0] axis_idx, axis_lim;
  logic             axis_out;
  assign axis_idx = prod_r[PROD_W-1:FRAC_W];
  assign axis_lim = (state_r == S_MULY) ? LIM_X : LIM_Y;
  assign axis_out = prod_r[PROD_W-1] || (axis_idx >= axis_lim);

  logic rd_out;
  assign rd_out = ({{(RCMP_W-RDIDX_W){1'b0}}, rcol_r} >= RLIM_X) ||
                  ({{(RCMP_W-RDIDX_W){1'b0}}, rrow_r} >= RLIM_Y);

  logic [COL_W-1:0]  a_col;
  logic [ROW_W-1:0]  a_row;
  logic [ADDR_W-1:0] a_addr;
  always_comb begin
    if (state_r == S_RADDR) begin
      a_col = COL_W'(rcol_r);
      a_row = ROW_W'(rrow_r);
    end else begin
      a_col = col_r;
      a_row = axis_idx[ROW_W-1:0];
    end
  end
  assign a_addr = ADDR_W'(a_row) * GW_A + ADDR_W'(a_col);

  // cell read-modify-write
  logic [CNT_W-1:0]  cnt_old;
  logic [SUM_W-1:0]  sum_old, sum_add, sum_new, sum_mag;
  logic              cell_full;
  assign cnt_old   = rdata_r[CNT_W-1:0];
  assign sum_old   = rdata_r[MEM_W-1:CNT_W];
  assign cell_full = (cnt_old == CNT_MAX);
  assign sum_mag   = sum_old[SUM_W-1] ? (~sum_old + 1'b1) : sum_old;

  always_comb begin
    case (kind_r)
      KIND_HEIGHT:    sum_add = {{(SUM_W-COORD_W){z_r[COORD_W-1]}}, z_r};
      KIND_INTENSITY: sum_add = {{(SUM_W-INTEN_W){1'b0}}, inten_r};
      default:        sum_add = '0;
    endcase
  end
  assign sum_new = sum_old + sum_add;

  logic div_start;
  assign div_start = (mode_r == MODE_READ) && !kind_r[1] && (cnt_old != '0);

  // restoring divider, one quotient bit per cycle
  logic [CNT_W:0]     div_shift, div_trial;
  logic               div_bit;
  logic [CNT_W-1:0]   rem_nxt;
  logic [SUM_W-1:0]   quo_nxt;
  logic [VALUE_W-1:0] q_low;
  assign div_shift = {rem_r, quo_r[SUM_W-1]};
  assign div_trial = div_shift - {1'b0, cnt_r};
  assign div_bit   = !div_trial[CNT_W];
  assign rem_nxt   = div_bit ? div_trial[CNT_W-1:0] : div_shift[CNT_W-1:0];
  assign quo_nxt   = {quo_r[SUM_W-2:0], div_bit};
  assign q_low     = quo_nxt[VALUE_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == LAST_ADDR) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) state_nxt = (in_mode == MODE_READ) ? S_RADDR : S_MULX;
      end
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_ADDR;
      S_ADDR:  state_nxt = (outside_r || axis_out) ? S_DONE : S_RD;
      S_RADDR: state_nxt = rd_out ? S_DONE : S_RD;
      S_RD:    state_nxt = S_RMW;
      S_RMW:   state_nxt = div_start ? S_DIV : S_DONE;
      S_DIV:   if (step_r == '0) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
      end
      S_IDLE: in_ready = 1'b1;
      S_RMW: begin
        if (mode_r == MODE_READ) begin
          mem_we = 1'b1;
        end else if (!cell_full) begin
          mem_we    = 1'b1;
          mem_wdata = {sum_new, cnt_old + 1'b1};
        end
      end
      S_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= '0;
      org_x_r <= '0;
      org_y_r <= '0;
      scl_x_r <= '0;
      scl_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KIND:     kind_r  <= cfg_wdata[KIND_W-1:0];
        CFG_ORIGIN_X: org_x_r <= cfg_wdata[COORD_W-1:0];
        CFG_ORIGIN_Y: org_y_r <= cfg_wdata[COORD_W-1:0];
        CFG_SCALE_X:  scl_x_r <= cfg_wdata[SCALE_W-1:0];
        CFG_SCALE_Y:  scl_y_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[addr_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_r    <= in_mode;
          x_r       <= in_point_x;
          y_r       <= in_point_y;
          z_r       <= in_point_z;
          inten_r   <= in_intensity;
          rcol_r    <= in_read_col;
          rrow_r    <= in_read_row;
          outside_r <= 1'b0;
          acc_r     <= 1'b0;
          sat_r     <= 1'b0;
        end
      end
      S_MULX: prod_r <= mul_p;
      S_MULY: begin
        prod_r    <= mul_p;
        outside_r <= axis_out;
        col_r     <= axis_idx[COL_W-1:0];
      end
      S_ADDR: begin
        outside_r <= outside_r || axis_out;
        row_r     <= axis_idx[ROW_W-1:0];
        addr_r    <= a_addr;
      end
      S_RADDR: begin
        outside_r <= rd_out;
        addr_r    <= a_addr;
      end
      S_RMW: begin
        if (mode_r == MODE_READ) begin
          cnt_r   <= cnt_old;
          value_r <= kind_r[1] ? VALUE_W'(cnt_old) : '0;
          neg_r   <= sum_old[SUM_W-1];
          quo_r   <= sum_mag;
          rem_r   <= '0;
          step_r  <= STEP_W'(SUM_W - 1);
        end else if (cell_full) begin
          sat_r <= 1'b1;
          cnt_r <= CNT_MAX;
        end else begin
          acc_r <= 1'b1;
          cnt_r <= cnt_old + 1'b1;
        end
      end
      S_DIV: begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r - 1'b1;
        if (step_r == '0) value_r <= neg_r ? (~q_low + 1'b1) : q_low;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_acc_r <= acc_r;
      out_out_r <= outside_r;
      out_sat_r <= sat_r;
      if (mode_r == MODE_READ) begin
        out_col_r <= rcol_r;
        out_row_r <= rrow_r;
      end else if (outside_r) begin
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        out_col_r <= RDIDX_W'(col_r);
        out_row_r <= RDIDX_W'(row_r);
      end
      out_cnt_r <= outside_r ? '0 : cnt_r;
      out_val_r <= ((mode_r == MODE_READ) && !outside_r) ? value_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_outside_grid = out_out_r;
  assign out_saturated    = out_sat_r;
  assign out_cell_col     = out_col_r;
  assign out_cell_row     = out_row_r;
  assign out_cell_value   = $signed(out_val_r);
  assign out_cell_count   = out_cnt_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_accept_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_accepted) |-> (!out_outside_grid && !out_saturated &&
                                     out_cell_count != '0))
    else $error("accepted result with conflicting flags or zero count");

  a_sat_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_cell_count == CNT_MAX))
    else $error("saturated result without full count");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final step");

endmodule

### sim/point_grid_binning_averager_checker.sv
module point_grid_binning_averager_checker #(
  parameter int GRID_WIDTH  = pgba_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = pgba_pkg::DEF_GRID_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pgba_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [pgba_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [pgba_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [pgba_pkg::COORD_W-1:0]  in_point_y,
  input  logic signed [pgba_pkg::COORD_W-1:0]  in_point_z,
  input  logic [pgba_pkg::INTEN_W-1:0]         in_intensity,
  input  logic [pgba_pkg::RDIDX_W-1:0]         in_read_col,
  input  logic [pgba_pkg::RDIDX_W-1:0]         in_read_row,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 out_accepted,
  input  logic                                 out_outside_grid,
  input  logic                                 out_saturated,
  input  logic [pgba_pkg::RDIDX_W-1:0]         out_cell_col,
  input  logic [pgba_pkg::RDIDX_W-1:0]         out_cell_row,
  input  logic signed [pgba_pkg::VALUE_W-1:0]  out_cell_value,
  input  logic [pgba_pkg::CNT_W-1:0]           out_cell_count,
  output int                                   mismatches,
  output int                                   outstanding
);
  import pgba_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int PRINT_CAP = 60;

  typedef struct packed {
    logic                      accepted;
    logic                      outside;
    logic                      saturated;
    logic [RDIDX_W-1:0]        col;
    logic [RDIDX_W-1:0]        row;
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          count;
  } cell_result_t;

  logic signed [SUM_W-1:0]   cell_sum [CELLS];
  logic [CNT_W-1:0]          cell_cnt [CELLS];
  logic [KIND_W-1:0]         kind;
  logic signed [COORD_W-1:0] org_x, org_y;
  logic [SCALE_W-1:0]        scl_x, scl_y;
  cell_result_t              due_results [$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic bit axis_cell(input logic signed [COORD_W-1:0] coord,
                                   input logic signed [COORD_W-1:0] origin,
                                   input logic [SCALE_W-1:0] scale,
                                   input int limit, output int bin);
    longint diff, prod, idx;
    diff = longint'(coord) - longint'(origin);
    prod = diff * longint'(scale);
    bin = 0;
    if (prod < 0) return 1'b0;
    idx = prod >>> FRAC_W;
    if (idx >= limit) return 1'b0;
    bin = int'(idx);
    return 1'b1;
  endfunction

  function automatic cell_result_t predict_cell_result(
      input logic mode,
      input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
      input logic signed [COORD_W-1:0] pz, input logic [INTEN_W-1:0] inten,
      input logic [RDIDX_W-1:0] rcol, input logic [RDIDX_W-1:0] rrow);
    cell_result_t r;
    int cx, cy, i;
    longint s, q;
    r = '0;
    if (mode == MODE_ADD) begin
      if (!axis_cell(px, org_x, scl_x, GRID_WIDTH, cx) ||
          !axis_cell(py, org_y, scl_y, GRID_HEIGHT, cy)) begin
        r.outside = 1'b1;
      end else begin
        i = cy * GRID_WIDTH + cx;
        r.col = cx[RDIDX_W-1:0];
        r.row = cy[RDIDX_W-1:0];
        if (cell_cnt[i] == CNT_MAX) begin
          r.saturated = 1'b1;
          r.count = CNT_MAX;
        end else begin
          if (kind == KIND_HEIGHT)
            cell_sum[i] = cell_sum[i] + pz;
          else if (kind == KIND_INTENSITY)
            cell_sum[i] = cell_sum[i] + $signed({1'b0, inten});
          cell_cnt[i] = cell_cnt[i] + 1'b1;
          r.accepted = 1'b1;
          r.count = cell_cnt[i];
        end
      end
    end else begin
      r.col = rcol;
      r.row = rrow;
      if (rcol >= GRID_WIDTH || rrow >= GRID_HEIGHT) begin
        r.outside = 1'b1;
      end else begin
        i = rrow * GRID_WIDTH + rcol;
        r.count = cell_cnt[i];
        if (kind != KIND_HEIGHT && kind != KIND_INTENSITY) begin
          r.value = VALUE_W'(cell_cnt[i]);
        end else if (cell_cnt[i] != 0) begin
          s = cell_sum[i];
          q = (s < 0 ? -s : s) / longint'(cell_cnt[i]);
          r.value = VALUE_W'((s < 0) ? -q : q);
        end
        cell_sum[i] = '0;
        cell_cnt[i] = '0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cell_result_t got, want;
    if (!rst_n) begin
      kind = KIND_HEIGHT;
      org_x = '0;
      org_y = '0;
      scl_x = '0;
      scl_y = '0;
      for (int k = 0; k < CELLS; k++) begin
        cell_sum[k] = '0;
        cell_cnt[k] = '0;
      end
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KIND:     kind  = cfg_wdata[KIND_W-1:0];
          CFG_ORIGIN_X: org_x = cfg_wdata[COORD_W-1:0];
          CFG_ORIGIN_Y: org_y = cfg_wdata[COORD_W-1:0];
          CFG_SCALE_X:  scl_x = cfg_wdata[SCALE_W-1:0];
          CFG_SCALE_Y:  scl_y = cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_accepted, out_outside_grid, out_saturated, out_cell_col, out_cell_row,
               out_cell_value, out_cell_count};
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with nothing due", longint'(0), longint'(0));
        end else begin
          want = due_results.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", longint'(got.accepted), longint'(want.accepted));
          if (got.outside !== want.outside)
            report_mismatch("outside_grid", longint'(got.outside), longint'(want.outside));
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", longint'(got.saturated), longint'(want.saturated));
          if (got.col !== want.col)
            report_mismatch("cell_col", longint'(got.col), longint'(want.col));
          if (got.row !== want.row)
            report_mismatch("cell_row", longint'(got.row), longint'(want.row));
          if (got.value !== want.value)
            report_mismatch("cell_value", longint'(got.value), longint'(want.value));
          if (got.count !== want.count)
            report_mismatch("cell_count", longint'(got.count), longint'(want.count));
        end
      end
      if (in_valid && in_ready)
        due_results.insert(due_results.size(),
                           predict_cell_result(in_mode, in_point_x, in_point_y,
                                               in_point_z, in_intensity,
                                               in_read_col, in_read_row));
    end
    outstanding = due_results.size();
  end

endmodule

### sim/point_grid_binning_averager_test.sv
module point_grid_binning_averager_test;
  import pgba_pkg::*;

  localparam logic [KIND_W-1:0] KIND_DENSITY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;
  localparam int DRAIN_CYCLES    = 60;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STEADY_ITEMS    = 150;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 170;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_idx;
  logic [CFG_DATA_W-1:0]     cfg_wdata;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_mode;
  logic signed [COORD_W-1:0] in_point_x, in_point_y, in_point_z;
  logic [INTEN_W-1:0]        in_intensity;
  logic [RDIDX_W-1:0]        in_read_col, in_read_row;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_accepted, out_outside_grid, out_saturated;
  logic [RDIDX_W-1:0]        out_cell_col, out_cell_row;
  logic signed [VALUE_W-1:0] out_cell_value;
  logic [CNT_W-1:0]          out_cell_count;

  int          mismatches;
  int          outstanding;
  bit          gaps_on;
  int          hold_cycles;
  int          cur_ox, cur_oy;
  logic [31:0] cur_sx, cur_sy;

  point_grid_binning_averager DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_intensity(in_intensity), .in_read_col(in_read_col), .in_read_row(in_read_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_outside_grid(out_outside_grid),
    .out_saturated(out_saturated), .out_cell_col(out_cell_col),
    .out_cell_row(out_cell_row), .out_cell_value(out_cell_value),
    .out_cell_count(out_cell_count)
  );

  point_grid_binning_averager_checker cell_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_intensity(in_intensity), .in_read_col(in_read_col), .in_read_row(in_read_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_outside_grid(out_outside_grid),
    .out_saturated(out_saturated), .out_cell_col(out_cell_col),
    .out_cell_row(out_cell_row), .out_cell_value(out_cell_value),
    .out_cell_count(out_cell_count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("point_grid_binning_averager: mismatch");
    $finish;
  end

  // result side: random stalls plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      out_ready = !(gaps_on && $urandom_range(0, 99) < 22);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(input logic mode,
                           input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z, input logic [INTEN_W-1:0] inten,
                           input logic [RDIDX_W-1:0] col, input logic [RDIDX_W-1:0] row);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    in_point_x = x;
    in_point_y = y;
    in_point_z = z;
    in_intensity = inten;
    in_read_col = col;
    in_read_row = row;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z, input logic [INTEN_W-1:0] inten);
    send_item(MODE_ADD, x, y, z, inten, RDIDX_W'($urandom), RDIDX_W'($urandom));
  endtask

  task automatic read_cell(input logic [RDIDX_W-1:0] col, input logic [RDIDX_W-1:0] row);
    send_item(MODE_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              INTEN_W'($urandom), col, row);
  endtask

  // coordinate that lands at or just below cell c for the given origin and scale
  function automatic logic [COORD_W-1:0] place(input int origin, input logic [31:0] scale,
                                               input int c);
    longint d;
    if (scale == 0)
      d = longint'($urandom_range(0, 4095));
    else
      d = ((longint'(c) << FRAC_W) + longint'($urandom_range(0, (1 << FRAC_W) - 1))) /
          longint'(scale);
    return COORD_W'(longint'(origin) + d);
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 32'h0100_0000;
      1: return 32'h0010_0000;
      2: return 32'h0800_0000;
      3: return $urandom;
      4: return $urandom_range(32'h0001_0000, 32'h0400_0000);
      default: return 32'h0;
    endcase
  endfunction

  task automatic random_setup();
    write_reg(CFG_KIND, CFG_DATA_W'($urandom_range(0, 3)));
    cur_ox = $urandom_range(0, 4194303) - 2097152;
    cur_oy = $urandom_range(0, 4194303) - 2097152;
    cur_sx = pick_scale();
    cur_sy = pick_scale();
    write_reg(CFG_ORIGIN_X, CFG_DATA_W'(cur_ox));
    write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(cur_oy));
    write_reg(CFG_SCALE_X, cur_sx);
    write_reg(CFG_SCALE_Y, cur_sy);
  endtask

  task automatic random_items(input int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        add_point(place(cur_ox, cur_sx, $urandom_range(0, 7)),
                  place(cur_oy, cur_sy, $urandom_range(0, 7)),
                  COORD_W'($urandom), INTEN_W'($urandom));
      else if (pick < 70)
        add_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  INTEN_W'($urandom));
      else if (pick < 95)
        read_cell(RDIDX_W'($urandom_range(0, 7)), RDIDX_W'($urandom_range(0, 7)));
      else
        read_cell(RDIDX_W'($urandom), RDIDX_W'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_KIND;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_ADD;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    in_intensity = '0;
    in_read_col = '0;
    in_read_row = '0;
    gaps_on = 1'b1;
    hold_cycles = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // unit scale: column and row equal the coordinate in mm
    write_reg(CFG_KIND, CFG_DATA_W'(KIND_HEIGHT));
    write_reg(CFG_ORIGIN_X, '0);
    write_reg(CFG_ORIGIN_Y, '0);
    write_reg(CFG_SCALE_X, 32'h0100_0000);
    write_reg(CFG_SCALE_Y, 32'h0100_0000);
    add_point(24'sd0, 24'sd0, 24'sh7FFFFF, 16'hFFFF);
    add_point(24'sd0, 24'sd0, -24'sh800000, 16'h0000);
    read_cell(6'd0, 6'd0);
    read_cell(6'd0, 6'd0);
    add_point(24'sd63, 24'sd63, -24'sd7, 16'h1234);
    add_point(24'sd63, 24'sd63, 24'sd0, 16'h0001);
    read_cell(6'd63, 6'd63);
    add_point(24'sd64, 24'sd0, 24'sd5, 16'h0000);
    add_point(-24'sd1, 24'sd5, 24'sd5, 16'h0000);
    add_point(24'sd5, -24'sh800000, 24'sd5, 16'h0000);
    add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sd5, 16'h0000);
    read_cell(6'd63, 6'd0);

    // extreme origins, maximum scale on x, zero scale on y
    settle();
    write_reg(CFG_KIND, CFG_DATA_W'(KIND_INTENSITY));
    write_reg(CFG_ORIGIN_X, 32'hFF80_0000);
    write_reg(CFG_ORIGIN_Y, 32'h007F_FFFF);
    write_reg(CFG_SCALE_X, 32'hFFFF_FFFF);
    write_reg(CFG_SCALE_Y, 32'h0);
    add_point(-24'sh800000, -24'sh800000, 24'sd1, 16'hFFFF);
    add_point(-24'sh800000, 24'sd0, 24'sd1, 16'h0000);
    add_point(-24'sh800000, 24'sh7FFFFF, 24'sd1, 16'h0001);
    add_point(-24'sh7FFFFF, 24'sd0, 24'sd1, 16'h0001);
    read_cell(6'd0, 6'd0);

    settle();
    write_reg(CFG_KIND, CFG_DATA_W'(KIND_DENSITY));
    add_point(-24'sh800000, 24'sd3, 24'sd100, 16'h0010);
    add_point(-24'sh800000, 24'sd4, 24'sd200, 16'h0020);
    read_cell(6'd0, 6'd0);

    settle();
    write_reg(CFG_KIND, CFG_DATA_W'(KIND_SPARE));
    add_point(-24'sh800000, 24'sd9, 24'sd300, 16'h0030);
    read_cell(6'd0, 6'd0);

    // steady stream into one cell; no idling here
    settle();
    write_reg(CFG_KIND, CFG_DATA_W'(KIND_HEIGHT));
    write_reg(CFG_SCALE_X, 32'h0);
    gaps_on = 1'b0;
    for (int k = 0; k < STEADY_ITEMS; k++)
      add_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                INTEN_W'($urandom));
    read_cell(6'd0, 6'd0);
    read_cell(6'd0, 6'd0);
    gaps_on = 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      random_setup();
      if (p == 2) begin
        @(negedge clk);
        hold_cycles = HOLD_OFF_CYCLES;
      end
      random_items(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("point_grid_binning_averager: match");
    else
      $display("point_grid_binning_averager: mismatch");
    $finish;
  end

endmodule

### filelist.f
rtl/core/pgba_pkg.sv
rtl/core/point_grid_binning_averager.sv
sim/point_grid_binning_averager_checker.sv
sim/point_grid_binning_averager_test.sv
